// ===== hdl/shp_pkg.sv =====
package shp_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned FracBitsDef    = 4;
  localparam int unsigned PeriodWidthDef = 16;

  // Field widths.
  localparam int unsigned TempW    = 16;
  localparam int unsigned GainW    = 8;
  localparam int unsigned PwrW     = 7;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutDataW = 16;
  // Setpoint - temperature + bias needs two bits above the 16-bit operands.
  localparam int unsigned ErrW     = TempW + 2;

  // Full power in percent.
  localparam logic [PwrW-1:0] PctFull = 7'd100;

  // Register reset values.
  localparam logic signed [TempW-1:0] SetpointRst = 16'sd80;
  localparam logic signed [TempW-1:0] BiasRst     = 16'sd0;
  localparam logic [GainW-1:0]        GainRst     = 8'd1;
  localparam logic [PwrW-1:0]         MinPwrRst   = 7'd0;
  localparam int unsigned             PeriodRst   = 1000;
  localparam logic                    EnableRst   = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT = 3'd0,
    REG_BIAS     = 3'd1,
    REG_GAIN     = 3'd2,
    REG_MIN_PWR  = 3'd3,
    REG_PERIOD   = 3'd4,
    REG_ENABLE   = 3'd5
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;
    logic prod;
    logic smp_apply;
    logic tick_step;
    logic mul;
    logic quot;
    logic ph_apply;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic smp_start;
    logic tick_expire;
  } dp_status_t;

endpackage

// ===== hdl/shp_dpath.sv =====
module shp_dpath #(
  parameter int unsigned FracBits    = shp_pkg::FracBitsDef,
  parameter int unsigned PeriodWidth = shp_pkg::PeriodWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [shp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [shp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [shp_pkg::TempW-1:0]        temp_i,
  input  logic                             mode_i,
  input  shp_pkg::dp_cmd_t                 cmd_i,
  output shp_pkg::dp_status_t              status_o,
  output logic [shp_pkg::OutDataW-1:0]     res_o
);

  localparam int unsigned ErrW  = shp_pkg::ErrW;
  localparam int unsigned PwrW  = shp_pkg::PwrW;
  localparam int unsigned ProdW = ErrW + shp_pkg::GainW + 1;
  localparam int unsigned DivW  = PeriodWidth + PwrW;
  // x / 100 equals (x * RecipMul) >> RecipShift for every x below 2**DivW, because
  // RecipMul * 100 exceeds 2**RecipShift by less than 128.
  localparam int unsigned RecipShift = DivW + 7;
  localparam logic [63:0] RecipMul   = ((64'd1 << RecipShift) + 64'd99) / 64'd100;
  localparam int unsigned QuotW      = RecipShift + PeriodWidth;

  // Configuration registers.
  logic signed [shp_pkg::TempW-1:0] setpoint_q, bias_q;
  logic [shp_pkg::GainW-1:0]        gain_q;
  logic [PwrW-1:0]                  min_pwr_q;
  logic [PeriodWidth-1:0]           period_q;
  logic                             enable_q;

  // Controller state.
  logic                   relay_q, run_q, armed_q;
  logic [PwrW-1:0]        power_q;
  logic [PeriodWidth-1:0] ticks_q;

  // Working registers.
  logic signed [ErrW-1:0]  err_q, err_d;
  logic                    cut_q, cut_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [ProdW-1:0]        prod_shr;
  logic [PwrW-1:0]         pwr_new;
  logic                    below_min;
  logic [DivW-1:0]         dvd_q;
  logic [QuotW-1:0]        quot_full;
  logic [PeriodWidth-1:0]  on_time_q, off_time;
  logic                    gt1;
  logic [shp_pkg::OutDataW-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= shp_pkg::SetpointRst;
      bias_q     <= shp_pkg::BiasRst;
      gain_q     <= shp_pkg::GainRst;
      min_pwr_q  <= shp_pkg::MinPwrRst;
      period_q   <= PeriodWidth'(shp_pkg::PeriodRst);
      enable_q   <= shp_pkg::EnableRst;
    end else if (cfg_valid_i) begin
      case (shp_pkg::cfg_reg_e'(cfg_index_i))
        shp_pkg::REG_SETPOINT: setpoint_q <= $signed(cfg_data_i);
        shp_pkg::REG_BIAS:     bias_q     <= $signed(cfg_data_i);
        shp_pkg::REG_GAIN:     gain_q     <= cfg_data_i[shp_pkg::GainW-1:0];
        shp_pkg::REG_MIN_PWR:  min_pwr_q  <= cfg_data_i[PwrW-1:0];
        shp_pkg::REG_PERIOD:   period_q   <= PeriodWidth'(cfg_data_i);
        shp_pkg::REG_ENABLE:   enable_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The error is exact in ErrW bits, so the cutoff test is simply err <= 0 or enable clear.
  assign err_d = ErrW'(setpoint_q) - ErrW'($signed(temp_i)) + ErrW'(bias_q);
  assign cut_d = !enable_q || err_d[ErrW-1] || (err_d == '0);

  assign prod_d   = ProdW'(err_q) * ProdW'($signed({1'b0, gain_q}));
  assign prod_shr = $unsigned(prod_q) >> FracBits;

  always_comb begin
    if (prod_q[ProdW-1] || (prod_q == '0)) begin
      pwr_new = '0;
    end else if (prod_shr > ProdW'(shp_pkg::PctFull)) begin
      pwr_new = shp_pkg::PctFull;
    end else begin
      pwr_new = prod_shr[PwrW-1:0];
    end
  end

  assign below_min = pwr_new < min_pwr_q;

  // On time is period * power / 100, the division done by a constant reciprocal.
  assign quot_full = QuotW'(dvd_q) * QuotW'(RecipMul);

  assign off_time = period_q - on_time_q;
  assign gt1      = ticks_q > PeriodWidth'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      err_q <= err_d;
      cut_q <= cut_d;
    end
    if (cmd_i.prod) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul) begin
      dvd_q <= DivW'(period_q) * DivW'(power_q);
    end
    if (cmd_i.quot) begin
      on_time_q <= quot_full[QuotW-1:RecipShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q <= 1'b0;
      run_q   <= 1'b0;
      power_q <= '0;
      armed_q <= 1'b0;
      ticks_q <= '0;
      res_q   <= '0;
    end else begin
      if (cmd_i.smp_apply) begin
        if (cut_q || below_min) begin
          run_q   <= 1'b0;
          power_q <= '0;
        end else begin
          power_q <= pwr_new;
          run_q   <= 1'b1;
        end
      end else if (cmd_i.tick_step && armed_q) begin
        if (gt1) begin
          ticks_q <= ticks_q - PeriodWidth'(1);
        end else begin
          ticks_q <= '0;
          armed_q <= 1'b0;
        end
      end else if (cmd_i.ph_apply) begin
        if (!relay_q) begin
          if (!run_q) begin
            armed_q <= 1'b0;
            ticks_q <= '0;
          end else if (on_time_q == '0) begin
            armed_q <= 1'b1;
            ticks_q <= period_q;
          end else begin
            relay_q <= 1'b1;
            armed_q <= 1'b1;
            ticks_q <= on_time_q;
          end
        end else begin
          if (!run_q) begin
            relay_q <= 1'b0;
            armed_q <= 1'b0;
            ticks_q <= '0;
          end else if ((off_time == '0) && (on_time_q != '0)) begin
            // Full power: the relay stays on into the next on phase.
            armed_q <= 1'b1;
            ticks_q <= on_time_q;
          end else begin
            relay_q <= 1'b0;
            armed_q <= 1'b1;
            ticks_q <= off_time;
          end
        end
      end
      if (cmd_i.out_load) begin
        res_q <= shp_pkg::OutDataW'({run_q, power_q, relay_q});
      end
    end
  end

  assign status_o.is_tick     = mode_i;
  assign status_o.smp_start   = !cut_q && !below_min && !run_q;
  assign status_o.tick_expire = armed_q && !gt1;
  assign res_o = res_q;

endmodule

// ===== hdl/shp_ctrl.sv =====
module shp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  shp_pkg::dp_status_t status_i,
  output shp_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SAMP,
    ST_TICK,
    ST_MUL,
    ST_QUOT,
    ST_PHASE,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   s_rdy_q, m_vld_q;
  logic   out_free;

  assign out_free = !m_vld_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s_rdy_q <= 1'b1;
      m_vld_q <= 1'b0;
    end else begin
      if (m_vld_q && m_ready_i && (state_q != ST_OUT)) begin
        m_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i && s_rdy_q) begin
            s_rdy_q <= 1'b0;
            state_q <= status_i.is_tick ? ST_TICK : ST_PROD;
          end
        end
        ST_PROD:  state_q <= ST_SAMP;
        ST_SAMP:  state_q <= status_i.smp_start ? ST_MUL : ST_OUT;
        ST_TICK:  state_q <= status_i.tick_expire ? ST_MUL : ST_OUT;
        ST_MUL:   state_q <= ST_QUOT;
        ST_QUOT:  state_q <= ST_PHASE;
        ST_PHASE: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            m_vld_q <= 1'b1;
            s_rdy_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.ld_item   = (state_q == ST_IDLE) && s_valid_i && s_rdy_q;
    cmd_o.prod      = state_q == ST_PROD;
    cmd_o.smp_apply = state_q == ST_SAMP;
    cmd_o.tick_step = state_q == ST_TICK;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.quot      = state_q == ST_QUOT;
    cmd_o.ph_apply  = state_q == ST_PHASE;
    cmd_o.out_load  = (state_q == ST_OUT) && out_free;
  end

  assign s_ready_o = s_rdy_q;
  assign m_valid_o = m_vld_q;

endmodule

// ===== hdl/ssr_time_proportional_heater.sv =====
// Time-proportioning heater drive for a solid-state relay.
//
// The slave stream carries one item per transfer: tuser is the mode (0 for a
// temperature sample, 1 for one time tick) and tdata the signed Q12.4
// temperature, which is ignored for a tick. Every item gives exactly one
// result on the master stream: relay level, power in percent and the running
// flag. The configuration channel writes one register per transfer and is
// always ready; it is meant to be used only while the block is idle.
//
// Items are handled one at a time by a small sequencer. A tick that does not
// end a timer phase passes a tick step and then the output state, and a
// sample that does not start a cycle the product, apply and output states;
// the block is ready again in the same cycle the result turns valid. An item
// that ends a phase or starts a cycle adds a state for the product
// period * power, one for the division by 100 as a multiplication by a
// constant reciprocal, and one to load the new phase.
//
// Reset puts every configuration register at its reset value, the relay off and the timer
// disarmed. The result sits in an output register; while the receiver stalls
// the next item may still be accepted and worked on, and its result waits
// until the register is free.
module ssr_time_proportional_heater #(
  parameter int unsigned FracBits    = shp_pkg::FracBitsDef,
  parameter int unsigned PeriodWidth = shp_pkg::PeriodWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [shp_pkg::TempW-1:0]    s_axis_tdata,   // [15:0] temperature
  input  logic                         s_axis_tuser,   // [0] mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] relay_on, [7:1] power_percent, [8] running, [15:9] zero
  output logic [shp_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [shp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [shp_pkg::CfgDataW-1:0] cfg_data_i
);

  shp_pkg::dp_cmd_t    cmd;
  shp_pkg::dp_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  shp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  shp_dpath #(
    .FracBits   (FracBits),
    .PeriodWidth(PeriodWidth)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .temp_i      (s_axis_tdata),
    .mode_i      (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (m_axis_tdata)
  );

endmodule

// ===== hdl/shp_chk.sv =====
module shp_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [shp_pkg::TempW-1:0]    s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [shp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [shp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [shp_pkg::CfgDataW-1:0] cfg_data_i
);

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] <= shp_pkg::PctFull))
    else $error("power above full scale");

  // Clearing the run flag always clears the power with it.
  a_stop_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:1] == '0))
    else $error("power left set while not running");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind ssr_time_proportional_heater shp_chk u_shp_chk (.*);
